@@ rtl/longest_bitonic_subsequence_assert.svh @@
// Assertion macros for the longest bitonic subsequence block.
`ifndef LONGEST_BITONIC_SUBSEQUENCE_ASSERT_SVH
`define LONGEST_BITONIC_SUBSEQUENCE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define LBS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define LBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lbs_pkg.sv @@
// Shared constants and controller/datapath interface types.
`default_nettype none
package lbs_pkg;

    localparam int MAX_LEN_DEF = 1024;
    localparam int VALUE_W     = 31;
    localparam int LENGTH_W    = 11;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 16;

    typedef struct packed {
        logic load;
        logic row_rd;
        logic pivot;
        logic scan;
        logic wr;
        logic fall;
        logic publish;
    } t_cmd;

    typedef struct packed {
        logic rise_end;
        logic fall_end;
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

@@ rtl/lbs_datapath.sv @@
// Datapath: element and length memories, row/column counters, maxima, result register.
`default_nettype none
module lbs_datapath #(
    parameter int MAX_LEN = lbs_pkg::MAX_LEN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [lbs_pkg::VALUE_W-1:0]   i_value,
    input  lbs_pkg::t_cmd                 i_cmd,
    output lbs_pkg::t_sts                 o_sts,
    input  logic                          i_m_tready,
    output logic                          o_out_valid,
    output logic [lbs_pkg::LENGTH_W-1:0]  o_length,
    output logic                          o_overflow
);
    import lbs_pkg::*;

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);

    logic [VALUE_W-1:0]  mem_elem [MAX_LEN];
    logic [CW-1:0]       mem_rise [MAX_LEN];
    logic [CW-1:0]       mem_fall [MAX_LEN];

    logic [VALUE_W-1:0]  r_elem_q;
    logic [CW-1:0]       r_rise_q;
    logic [CW-1:0]       r_fall_q;

    logic [CW-1:0]       r_n;
    logic [CW-1:0]       r_i;
    logic [CW-1:0]       r_j;
    logic                r_v;
    logic                r_ovf;
    logic [VALUE_W-1:0]  r_pivot;
    logic [CW-1:0]       r_prise;
    logic [CW-1:0]       r_acc;
    logic [CW-1:0]       r_best;
    logic                r_out_valid;
    logic [LENGTH_W-1:0] r_out_len;
    logic                r_out_ovf;

    logic [CW-1:0]       w_end;
    logic                w_scan_go;
    logic [AW-1:0]       w_rd_addr;
    logic [CW-1:0]       w_len_q;
    logic [CW:0]         w_cand;
    logic                w_take;
    logic [CW:0]         w_total;
    logic                w_load;
    logic                w_room;
    logic                w_out_free;

    assign w_end      = i_cmd.fall ? r_n : r_i;
    assign w_scan_go  = (r_j < w_end);
    assign w_rd_addr  = i_cmd.row_rd ? r_i[AW-1:0] : r_j[AW-1:0];
    assign w_len_q    = i_cmd.fall ? r_fall_q : r_rise_q;
    assign w_cand     = {1'b0, w_len_q} + (CW+1)'(1);
    assign w_take     = r_v && (r_elem_q < r_pivot) && (w_cand > {1'b0, r_acc});
    assign w_total    = {1'b0, r_prise} + {1'b0, r_acc} - (CW+1)'(1);
    assign w_load     = i_cmd.load && i_valid;
    assign w_room     = (r_n < CW'(MAX_LEN));
    assign w_out_free = !r_out_valid || i_m_tready;

    assign o_sts.rise_end  = ((r_i + CW'(1)) == r_n);
    assign o_sts.fall_end  = (r_i == '0);
    assign o_sts.scan_done = !w_scan_go && !r_v;
    assign o_sts.out_free  = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_length    = r_out_len;
    assign o_overflow  = r_out_ovf;

    always_ff @(posedge i_clk) begin
        if (w_load && w_room) begin
            mem_elem[r_n[AW-1:0]] <= i_value;
        end
        r_elem_q <= mem_elem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && !i_cmd.fall) begin
            mem_rise[r_i[AW-1:0]] <= r_acc;
        end
        r_rise_q <= mem_rise[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && i_cmd.fall) begin
            mem_fall[r_i[AW-1:0]] <= r_acc;
        end
        r_fall_q <= mem_fall[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n         <= '0;
            r_ovf       <= 1'b0;
            r_best      <= '0;
            r_v         <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                if (w_room) begin
                    r_n <= r_n + CW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.row_rd) begin
                r_v <= 1'b0;
            end else if (i_cmd.scan) begin
                r_v <= w_scan_go;
            end
            if (i_cmd.wr && i_cmd.fall && (r_acc >= CW'(2))
                && (w_total > {1'b0, r_best})) begin
                r_best <= w_total[CW-1:0];
            end
            if (i_cmd.publish) begin
                r_out_valid <= 1'b1;
                r_n         <= '0;
                r_ovf       <= 1'b0;
                r_best      <= '0;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_i <= '0;
        end
        if (i_cmd.row_rd) begin
            r_j   <= i_cmd.fall ? (r_i + CW'(1)) : '0;
            r_acc <= CW'(1);
        end
        if (i_cmd.pivot) begin
            r_pivot <= r_elem_q;
            r_prise <= r_rise_q;
        end
        if (i_cmd.scan) begin
            if (w_scan_go) begin
                r_j <= r_j + CW'(1);
            end
            if (w_take) begin
                r_acc <= w_cand[CW-1:0];
            end
        end
        if (i_cmd.wr) begin
            if (!i_cmd.fall && !o_sts.rise_end) begin
                r_i <= r_i + CW'(1);
            end else if (i_cmd.fall && !o_sts.fall_end) begin
                r_i <= r_i - CW'(1);
            end
        end
        if (i_cmd.publish) begin
            r_out_len <= LENGTH_W'(r_best);
            r_out_ovf <= r_ovf;
        end
    end

endmodule
`default_nettype wire

@@ rtl/lbs_ctrl.sv @@
// Controller: sequences loading, rise rows, fall rows and result hand-off.
`default_nettype none
module lbs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    input  logic          i_s_tlast,
    input  lbs_pkg::t_sts i_sts,
    output lbs_pkg::t_cmd o_cmd
);
    import lbs_pkg::*;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_R_ROW,
        ST_R_PIV,
        ST_R_SCAN,
        ST_R_WR,
        ST_F_ROW,
        ST_F_PIV,
        ST_F_SCAN,
        ST_F_WR,
        ST_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_LOAD: begin
                o_cmd.load = 1'b1;
                if (i_s_tvalid && i_s_tlast) begin
                    n_state = ST_R_ROW;
                end
            end
            ST_R_ROW: begin
                o_cmd.row_rd = 1'b1;
                n_state      = ST_R_PIV;
            end
            ST_R_PIV: begin
                o_cmd.pivot = 1'b1;
                n_state     = ST_R_SCAN;
            end
            ST_R_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = ST_R_WR;
                end
            end
            ST_R_WR: begin
                o_cmd.wr = 1'b1;
                n_state  = i_sts.rise_end ? ST_F_ROW : ST_R_ROW;
            end
            ST_F_ROW: begin
                o_cmd.fall   = 1'b1;
                o_cmd.row_rd = 1'b1;
                n_state      = ST_F_PIV;
            end
            ST_F_PIV: begin
                o_cmd.fall  = 1'b1;
                o_cmd.pivot = 1'b1;
                n_state     = ST_F_SCAN;
            end
            ST_F_SCAN: begin
                o_cmd.fall = 1'b1;
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = ST_F_WR;
                end
            end
            ST_F_WR: begin
                o_cmd.fall = 1'b1;
                o_cmd.wr   = 1'b1;
                n_state    = i_sts.fall_end ? ST_DONE : ST_F_ROW;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/longest_bitonic_subsequence.sv @@
// Top level: longest bitonic subsequence engine, controller plus datapath.
//
//  Channel | Direction | tdata (low bit up)         | tuser    | tlast
//  s_*     | in        | value[30:0], pad[31]       | -        | last
//  m_*     | out       | length[10:0], pad[15:11]   | overflow | -
//
// Elements load at one request per cycle into the element memory.
// After the last request the engine works through the n stored elements in
// row scans, its run time set by the single read port of each memory.
// Input is not ready from the last request until the result enters the output
// register; a result waits there until taken. Reset is synchronous and clears
// the element count, best length, flags and state; the memories are not cleared.
`default_nettype none
module longest_bitonic_subsequence #(
    parameter int MAX_LEN = lbs_pkg::MAX_LEN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [lbs_pkg::S_TDATA_W-1:0]  i_s_tdata,   // value[30:0]
    input  logic                           i_s_tlast,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [lbs_pkg::M_TDATA_W-1:0]  o_m_tdata,   // length[10:0]
    output logic                           o_m_tuser    // overflow
);
    import lbs_pkg::*;

    t_cmd                w_cmd;
    t_sts                w_sts;
    logic [LENGTH_W-1:0] w_length;

    lbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    lbs_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .i_value     (i_s_tdata[VALUE_W-1:0]),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_m_tready  (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_length    (w_length),
        .o_overflow  (o_m_tuser)
    );

    assign o_s_tready = w_cmd.load;
    assign o_m_tdata  = M_TDATA_W'(w_length);

`include "longest_bitonic_subsequence_assert.svh"

    `LBS_ASSERT_NEXT(a_last_stops_input, i_clk, i_rst_n, i_s_tvalid && o_s_tready && i_s_tlast, !o_s_tready, "input still ready after last request")
    `LBS_ASSERT_SAME(a_ready_drop_on_last, i_clk, i_rst_n, $fell(o_s_tready), $past(i_s_tvalid && i_s_tlast), "ready dropped without a last request")
    `LBS_ASSERT_SAME(a_result_after_compute, i_clk, i_rst_n, $rose(o_m_tvalid), $past(!o_s_tready), "result appeared while loading")

endmodule
`default_nettype wire
